FILE: src/page_mapped_ftl_greedy_gc_assert.svh
// Assertion macros shared by the FTL controller and datapath.
// Depends on clk_i and rst_ni being visible in the module that expands them.
`ifndef PAGE_MAPPED_FTL_GREEDY_GC_ASSERT_SVH
`define PAGE_MAPPED_FTL_GREEDY_GC_ASSERT_SVH

// Plain property, checked on every rising edge outside reset.
`define PMFG_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Same-cycle implication.
`define PMFG_ASSERT_IMP(lbl, ante, cons, msg) \
  `PMFG_ASSERT(lbl, (ante) |-> (cons), msg)

`endif

FILE: src/pmfg_pkg.sv
// Shared constants, command codes and control structs for the FTL block.
// No dependencies.
`timescale 1ns / 1ps

package pmfg_pkg;

  localparam int PPB        = 64;
  localparam int NUM_BLOCKS = 64;
  localparam int MAX_LP     = 4096;
  localparam int PHYS_PAGES = NUM_BLOCKS * PPB;

  localparam int BLK_W  = $clog2(NUM_BLOCKS);
  localparam int PG_W   = $clog2(PPB);
  localparam int PPN_W  = $clog2(PHYS_PAGES);
  localparam int LPN_W  = $clog2(MAX_LP);
  localparam int ENT_W  = 13;
  localparam int VC_W   = $clog2(PPB + 2);
  localparam int AP_W   = $clog2(PPB + 1);
  localparam int ROOM_W = AP_W + 1;
  localparam int CNT_W  = 48;
  localparam int BIU_W  = 7;
  localparam int LPL_W  = 13;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 13;
  localparam int ST_W   = 2;

  localparam logic [BIU_W-1:0] BIU_RESET = BIU_W'(64);
  localparam logic [LPL_W-1:0] LPL_RESET = LPL_W'(3584);

  localparam logic [CFG_IDX_W-1:0] CFG_BLOCKS_IN_USE = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_LOGICAL_PAGES = CFG_IDX_W'(1);

  localparam logic [ST_W-1:0] ST_OK     = ST_W'(0);
  localparam logic [ST_W-1:0] ST_RANGE  = ST_W'(1);
  localparam logic [ST_W-1:0] ST_WEDGED = ST_W'(2);

  typedef enum logic [3:0] {
    CMD_NONE,
    CMD_CLEAR,
    CMD_ACCEPT,
    CMD_CHECK,
    CMD_SCAN,
    CMD_RD_REL,
    CMD_CHK_REL,
    CMD_MOVE,
    CMD_ERASE,
    CMD_RD_FWD,
    CMD_RD_OLD,
    CMD_INVAL,
    CMD_HOST_PROG,
    CMD_RESULT
  } cmd_e;

  typedef struct packed {
    cmd_e op;
  } cmd_t;

  typedef struct packed {
    logic clr_last;
    logic oor;
    logic need_gc;
    logic scan_last;
    logic gc_go;
    logic rel_valid;
    logic rel_last;
    logic slot_ok;
  } stat_t;

endpackage

FILE: src/pmfg_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
`timescale 1ns / 1ps

module pmfg_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: src/pmfg_dp.sv
// Datapath: maps, valid counts, append point, counters and result register.
// Depends on pmfg_pkg, pmfg_ram and the assertion macro header.
`timescale 1ns / 1ps
`include "page_mapped_ftl_greedy_gc_assert.svh"

module pmfg_dp (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  pmfg_pkg::cmd_t                    cmd_i,
  output pmfg_pkg::stat_t                   stat_o,
  input  logic                              cfg_valid_i,
  input  logic [pmfg_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [pmfg_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  input  logic [pmfg_pkg::LPN_W-1:0]        logical_page_i,
  output logic [pmfg_pkg::PPN_W-1:0]        physical_page_o,
  output logic [pmfg_pkg::AP_W-1:0]         relocated_count_o,
  output logic                              gc_ran_o,
  output logic [pmfg_pkg::BLK_W-1:0]        victim_block_o,
  output logic [pmfg_pkg::ST_W-1:0]         status_o,
  output logic [pmfg_pkg::CNT_W-1:0]        total_host_writes_o,
  output logic [pmfg_pkg::CNT_W-1:0]        total_flash_writes_o,
  output logic [pmfg_pkg::CNT_W-1:0]        total_erases_o
);

  localparam int NB = pmfg_pkg::NUM_BLOCKS;

  // configuration
  logic [pmfg_pkg::BIU_W-1:0] biu_q;
  logic [pmfg_pkg::LPL_W-1:0] lpl_q;

  // sequencing state
  logic [pmfg_pkg::PPN_W-1:0] clr_q;
  logic [pmfg_pkg::LPN_W-1:0] lpn_q;
  logic [pmfg_pkg::AP_W-1:0]  sc_q;
  logic [pmfg_pkg::VC_W-1:0]  best_q;
  logic [pmfg_pkg::BLK_W-1:0] victim_q;
  logic                       vfound_q;
  logic [pmfg_pkg::PG_W-1:0]  j_q;
  logic [pmfg_pkg::LPN_W-1:0] rel_lpn_q;
  logic                       fv_q;
  logic [pmfg_pkg::PPN_W-1:0] op_q;

  // append point and block state
  logic [pmfg_pkg::BLK_W-1:0] ab_q;
  logic [pmfg_pkg::AP_W-1:0]  ap_q;
  logic [pmfg_pkg::VC_W-1:0]  app_vc_q;
  logic [NB-1:0]              free_q;

  // per-item and running results
  logic [pmfg_pkg::AP_W-1:0]  moved_q;
  logic                       ran_q;
  logic [pmfg_pkg::ST_W-1:0]  status_q;
  logic [pmfg_pkg::PPN_W-1:0] ppn_q;
  logic [pmfg_pkg::CNT_W-1:0] host_q;
  logic [pmfg_pkg::CNT_W-1:0] flash_q;
  logic [pmfg_pkg::CNT_W-1:0] erase_q;

  logic [pmfg_pkg::PPN_W-1:0] res_ppn_q;
  logic [pmfg_pkg::AP_W-1:0]  res_moved_q;
  logic                       res_ran_q;
  logic [pmfg_pkg::BLK_W-1:0] res_victim_q;
  logic [pmfg_pkg::ST_W-1:0]  res_status_q;
  logic [pmfg_pkg::CNT_W-1:0] res_host_q;
  logic [pmfg_pkg::CNT_W-1:0] res_flash_q;
  logic [pmfg_pkg::CNT_W-1:0] res_erase_q;

  // memory ports
  logic                       fwd_we, rev_we, vc_we;
  logic [pmfg_pkg::LPN_W-1:0] fwd_waddr, fwd_raddr;
  logic [pmfg_pkg::PPN_W-1:0] rev_waddr, rev_raddr;
  logic [pmfg_pkg::BLK_W-1:0] vc_waddr, vc_raddr;
  logic [pmfg_pkg::ENT_W-1:0] fwd_wdata, fwd_rdata, rev_wdata, rev_rdata;
  logic [pmfg_pkg::VC_W-1:0]  vc_wdata, vc_rdata;

  // combinational helpers
  logic [pmfg_pkg::BIU_W-1:0] managed;
  logic [pmfg_pkg::LPL_W-1:0] limit;
  logic [NB-1:0]              mmask, free_m, ff_mask;
  logic [pmfg_pkg::BLK_W-1:0] ff_idx;
  logic                       ff_any;
  logic                       need_open, prog_ok;
  logic [pmfg_pkg::BLK_W-1:0] eff_ab;
  logic [pmfg_pkg::PG_W-1:0]  eff_ap;
  logic [pmfg_pkg::PPN_W-1:0] prog_ppn;
  logic [pmfg_pkg::VC_W-1:0]  prog_vc;
  logic [pmfg_pkg::LPN_W-1:0] prog_lpn;
  logic [pmfg_pkg::ROOM_W-1:0] room;
  logic [pmfg_pkg::BLK_W-1:0] sc_idx;
  logic                       sc_hit;
  logic                       old_live;
  logic [pmfg_pkg::BLK_W-1:0] ob;
  logic [pmfg_pkg::VC_W-1:0]  vc_dec;
  logic                       slot_ok;

  pmfg_ram #(.WIDTH(pmfg_pkg::ENT_W), .DEPTH(pmfg_pkg::MAX_LP)) u_fwd (
    .clk_i, .we_i(fwd_we), .waddr_i(fwd_waddr), .wdata_i(fwd_wdata),
    .raddr_i(fwd_raddr), .rdata_o(fwd_rdata)
  );

  pmfg_ram #(.WIDTH(pmfg_pkg::ENT_W), .DEPTH(pmfg_pkg::PHYS_PAGES)) u_rev (
    .clk_i, .we_i(rev_we), .waddr_i(rev_waddr), .wdata_i(rev_wdata),
    .raddr_i(rev_raddr), .rdata_o(rev_rdata)
  );

  pmfg_ram #(.WIDTH(pmfg_pkg::VC_W), .DEPTH(NB)) u_vc (
    .clk_i, .we_i(vc_we), .waddr_i(vc_waddr), .wdata_i(vc_wdata),
    .raddr_i(vc_raddr), .rdata_o(vc_rdata)
  );

  always_comb begin
    managed = (biu_q > pmfg_pkg::BIU_W'(NB)) ? pmfg_pkg::BIU_W'(NB) : biu_q;
    limit = (lpl_q > pmfg_pkg::LPL_W'(pmfg_pkg::MAX_LP)) ?
            pmfg_pkg::LPL_W'(pmfg_pkg::MAX_LP) : lpl_q;
    for (int b = 0; b < NB; b++) begin
      mmask[b] = (pmfg_pkg::BIU_W'(b) < managed);
    end
    // free managed blocks other than the append block
    free_m  = free_q & mmask & ~(NB'(1) << ab_q);
    ff_mask = (cmd_i.op == pmfg_pkg::CMD_MOVE) ? (free_m & ~(NB'(1) << victim_q)) : free_m;
    ff_idx = '0;
    ff_any = 1'b0;
    for (int b = NB - 1; b >= 0; b--) begin
      if (ff_mask[b]) begin
        ff_idx = pmfg_pkg::BLK_W'(b);
        ff_any = 1'b1;
      end
    end
    need_open = (ap_q >= pmfg_pkg::AP_W'(pmfg_pkg::PPB));
    prog_ok   = !need_open || ff_any;
    eff_ab    = need_open ? ff_idx : ab_q;
    eff_ap    = need_open ? '0 : ap_q[pmfg_pkg::PG_W-1:0];
    prog_ppn  = {eff_ab, eff_ap};
    prog_vc   = (need_open ? '0 : app_vc_q) + pmfg_pkg::VC_W'(1);
    prog_lpn  = (cmd_i.op == pmfg_pkg::CMD_MOVE) ? rel_lpn_q : lpn_q;

    room = ((free_m != '0) ? pmfg_pkg::ROOM_W'(pmfg_pkg::PPB) : '0) +
           (need_open ? '0 : (pmfg_pkg::ROOM_W'(pmfg_pkg::PPB) - pmfg_pkg::ROOM_W'(ap_q)));

    sc_idx = pmfg_pkg::BLK_W'(sc_q - pmfg_pkg::AP_W'(1));
    sc_hit = (sc_q != '0) && (pmfg_pkg::BIU_W'(sc_idx) < managed) && (sc_idx != ab_q) &&
             (vc_rdata != '0) && (vc_rdata < best_q);

    old_live = fv_q && rev_rdata[pmfg_pkg::ENT_W-1];
    ob       = op_q[pmfg_pkg::PPN_W-1 -: pmfg_pkg::BLK_W];
    vc_dec   = (vc_rdata == '0) ? '0 : vc_rdata - pmfg_pkg::VC_W'(1);
    // a slot exists if the append block has room, a free block exists, or the
    // invalidation empties a managed block
    slot_ok  = !need_open || (free_m != '0) ||
               (old_live && (pmfg_pkg::BIU_W'(ob) < managed) && (ob != ab_q) &&
                (vc_rdata == pmfg_pkg::VC_W'(1)));
  end

  always_comb begin
    stat_o.clr_last  = (clr_q == '1);
    stat_o.oor       = ({1'b0, lpn_q} >= limit);
    stat_o.need_gc   = ((free_m & (free_m - NB'(1))) == '0);
    stat_o.scan_last = (sc_q == pmfg_pkg::AP_W'(NB));
    stat_o.gc_go     = vfound_q && (pmfg_pkg::ROOM_W'(best_q) <= room);
    stat_o.rel_valid = rev_rdata[pmfg_pkg::ENT_W-1];
    stat_o.rel_last  = (j_q == '1);
    stat_o.slot_ok   = slot_ok;
  end

  // memory port steering
  always_comb begin
    fwd_we = 1'b0; fwd_waddr = lpn_q; fwd_wdata = '0; fwd_raddr = lpn_q;
    rev_we = 1'b0; rev_waddr = prog_ppn; rev_wdata = '0; rev_raddr = {victim_q, j_q};
    vc_we  = 1'b0; vc_waddr = eff_ab; vc_wdata = prog_vc; vc_raddr = sc_q[pmfg_pkg::BLK_W-1:0];
    case (cmd_i.op)
      pmfg_pkg::CMD_CLEAR: begin
        fwd_we = 1'b1; fwd_waddr = pmfg_pkg::LPN_W'(clr_q);
        rev_we = 1'b1; rev_waddr = clr_q;
        vc_we  = (clr_q < pmfg_pkg::PPN_W'(NB));
        vc_waddr = clr_q[pmfg_pkg::BLK_W-1:0]; vc_wdata = '0;
      end
      pmfg_pkg::CMD_CHK_REL: begin
        rev_we = rev_rdata[pmfg_pkg::ENT_W-1];
        rev_waddr = {victim_q, j_q};
      end
      pmfg_pkg::CMD_MOVE, pmfg_pkg::CMD_HOST_PROG: begin
        fwd_we = 1'b1; fwd_waddr = prog_lpn;
        fwd_wdata = prog_ok ? {1'b1, prog_ppn} : '0;
        rev_we = prog_ok; rev_wdata = {1'b1, prog_lpn};
        vc_we  = prog_ok;
      end
      pmfg_pkg::CMD_ERASE: begin
        vc_we = 1'b1; vc_waddr = victim_q; vc_wdata = '0;
      end
      pmfg_pkg::CMD_RD_OLD: begin
        rev_raddr = fwd_rdata[pmfg_pkg::PPN_W-1:0];
        vc_raddr  = fwd_rdata[pmfg_pkg::PPN_W-1 -: pmfg_pkg::BLK_W];
      end
      pmfg_pkg::CMD_INVAL: begin
        rev_we = slot_ok && old_live; rev_waddr = op_q;
        vc_we  = slot_ok && old_live; vc_waddr = ob; vc_wdata = vc_dec;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      biu_q <= pmfg_pkg::BIU_RESET;
      lpl_q <= pmfg_pkg::LPL_RESET;
      clr_q <= '0;
      lpn_q <= '0;
      sc_q <= '0;
      best_q <= '0;
      victim_q <= '0;
      vfound_q <= 1'b0;
      j_q <= '0;
      rel_lpn_q <= '0;
      fv_q <= 1'b0;
      op_q <= '0;
      ab_q <= '0;
      ap_q <= '0;
      app_vc_q <= '0;
      free_q <= '1;
      moved_q <= '0;
      ran_q <= 1'b0;
      status_q <= pmfg_pkg::ST_OK;
      ppn_q <= '0;
      host_q <= '0;
      flash_q <= '0;
      erase_q <= '0;
      res_ppn_q <= '0;
      res_moved_q <= '0;
      res_ran_q <= 1'b0;
      res_victim_q <= '0;
      res_status_q <= pmfg_pkg::ST_OK;
      res_host_q <= '0;
      res_flash_q <= '0;
      res_erase_q <= '0;
    end else begin
      if (cfg_valid_i) begin
        case (cfg_index_i)
          pmfg_pkg::CFG_BLOCKS_IN_USE: biu_q <= cfg_data_i[pmfg_pkg::BIU_W-1:0];
          pmfg_pkg::CFG_LOGICAL_PAGES: lpl_q <= cfg_data_i[pmfg_pkg::LPL_W-1:0];
          default: ;
        endcase
      end
      case (cmd_i.op)
        pmfg_pkg::CMD_CLEAR: clr_q <= clr_q + pmfg_pkg::PPN_W'(1);
        pmfg_pkg::CMD_ACCEPT: begin
          lpn_q <= logical_page_i;
          moved_q <= '0;
          ran_q <= 1'b0;
          status_q <= pmfg_pkg::ST_OK;
          ppn_q <= '0;
          sc_q <= '0;
          best_q <= pmfg_pkg::VC_W'(pmfg_pkg::PPB + 1);
          vfound_q <= 1'b0;
          j_q <= '0;
        end
        pmfg_pkg::CMD_CHECK: begin
          if (stat_o.oor) begin
            status_q <= pmfg_pkg::ST_RANGE;
          end
        end
        pmfg_pkg::CMD_SCAN: begin
          sc_q <= sc_q + pmfg_pkg::AP_W'(1);
          if (sc_hit) begin
            best_q <= vc_rdata;
            victim_q <= sc_idx;
            vfound_q <= 1'b1;
          end
        end
        pmfg_pkg::CMD_CHK_REL: begin
          rel_lpn_q <= rev_rdata[pmfg_pkg::LPN_W-1:0];
          if (!rev_rdata[pmfg_pkg::ENT_W-1]) begin
            j_q <= j_q + pmfg_pkg::PG_W'(1);
          end
        end
        pmfg_pkg::CMD_MOVE: begin
          j_q <= j_q + pmfg_pkg::PG_W'(1);
          if (prog_ok) begin
            ab_q <= eff_ab;
            ap_q <= pmfg_pkg::AP_W'(eff_ap) + pmfg_pkg::AP_W'(1);
            app_vc_q <= prog_vc;
            free_q[eff_ab] <= 1'b0;
            moved_q <= moved_q + pmfg_pkg::AP_W'(1);
            flash_q <= flash_q + pmfg_pkg::CNT_W'(1);
          end
        end
        pmfg_pkg::CMD_ERASE: begin
          free_q[victim_q] <= 1'b1;
          erase_q <= erase_q + pmfg_pkg::CNT_W'(1);
          ran_q <= 1'b1;
        end
        pmfg_pkg::CMD_RD_OLD: begin
          fv_q <= fwd_rdata[pmfg_pkg::ENT_W-1];
          op_q <= fwd_rdata[pmfg_pkg::PPN_W-1:0];
        end
        pmfg_pkg::CMD_INVAL: begin
          if (slot_ok) begin
            host_q <= host_q + pmfg_pkg::CNT_W'(1);
            if (old_live) begin
              free_q[ob] <= (vc_dec == '0);
              if (ob == ab_q && app_vc_q != '0) begin
                app_vc_q <= app_vc_q - pmfg_pkg::VC_W'(1);
              end
            end
          end else begin
            status_q <= pmfg_pkg::ST_WEDGED;
          end
        end
        pmfg_pkg::CMD_HOST_PROG: begin
          if (prog_ok) begin
            ab_q <= eff_ab;
            ap_q <= pmfg_pkg::AP_W'(eff_ap) + pmfg_pkg::AP_W'(1);
            app_vc_q <= prog_vc;
            free_q[eff_ab] <= 1'b0;
            ppn_q <= prog_ppn;
            flash_q <= flash_q + pmfg_pkg::CNT_W'(1);
          end else begin
            ppn_q <= '0;
            status_q <= pmfg_pkg::ST_WEDGED;
          end
        end
        pmfg_pkg::CMD_RESULT: begin
          res_ppn_q <= ppn_q;
          res_moved_q <= moved_q;
          res_ran_q <= ran_q;
          res_victim_q <= ran_q ? victim_q : '0;
          res_status_q <= status_q;
          res_host_q <= host_q;
          res_flash_q <= flash_q;
          res_erase_q <= erase_q;
        end
        default: ;
      endcase
    end
  end

  assign physical_page_o      = res_ppn_q;
  assign relocated_count_o    = res_moved_q;
  assign gc_ran_o             = res_ran_q;
  assign victim_block_o       = res_victim_q;
  assign status_o             = res_status_q;
  assign total_host_writes_o  = res_host_q;
  assign total_flash_writes_o = res_flash_q;
  assign total_erases_o       = res_erase_q;

  `PMFG_ASSERT(a_ap_bound, ap_q <= pmfg_pkg::AP_W'(pmfg_pkg::PPB), "append page past block end")
  `PMFG_ASSERT(a_free_mirror, free_q[ab_q] == (app_vc_q == '0), "free flag out of sync")
  `PMFG_ASSERT_IMP(a_no_self_target, (cmd_i.op == pmfg_pkg::CMD_MOVE) && prog_ok, eff_ab != victim_q, "relocation into victim")

endmodule

FILE: src/pmfg_ctrl.sv
// Controller: sequences clear sweep, collection and host write steps.
// Depends on pmfg_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "page_mapped_ftl_greedy_gc_assert.svh"

module pmfg_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  input  pmfg_pkg::stat_t stat_i,
  output pmfg_pkg::cmd_t  cmd_o
);

  localparam logic [3:0] S_CLEAR = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_CHK   = 4'd2;
  localparam logic [3:0] S_SCAN  = 4'd3;
  localparam logic [3:0] S_GDEC  = 4'd4;
  localparam logic [3:0] S_RREL  = 4'd5;
  localparam logic [3:0] S_CREL  = 4'd6;
  localparam logic [3:0] S_MOVE  = 4'd7;
  localparam logic [3:0] S_ERASE = 4'd8;
  localparam logic [3:0] S_HFWD  = 4'd9;
  localparam logic [3:0] S_HOLD  = 4'd10;
  localparam logic [3:0] S_HINV  = 4'd11;
  localparam logic [3:0] S_HPROG = 4'd12;
  localparam logic [3:0] S_DONE  = 4'd13;

  logic [3:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;

  always_comb begin
    state_d     = state_q;
    cmd_o.op    = pmfg_pkg::CMD_NONE;
    out_valid_d = out_valid_q && !out_ready_i;
    in_ready_o  = (state_q == S_IDLE);
    unique case (state_q)
      S_CLEAR: begin
        cmd_o.op = pmfg_pkg::CMD_CLEAR;
        if (stat_i.clr_last) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.op = pmfg_pkg::CMD_ACCEPT;
          state_d  = S_CHK;
        end
      end
      S_CHK: begin
        cmd_o.op = pmfg_pkg::CMD_CHECK;
        if (stat_i.oor) state_d = S_DONE;
        else if (stat_i.need_gc) state_d = S_SCAN;
        else state_d = S_HFWD;
      end
      S_SCAN: begin
        cmd_o.op = pmfg_pkg::CMD_SCAN;
        if (stat_i.scan_last) state_d = S_GDEC;
      end
      S_GDEC: state_d = stat_i.gc_go ? S_RREL : S_HFWD;
      S_RREL: begin
        cmd_o.op = pmfg_pkg::CMD_RD_REL;
        state_d  = S_CREL;
      end
      S_CREL: begin
        cmd_o.op = pmfg_pkg::CMD_CHK_REL;
        if (stat_i.rel_valid) state_d = S_MOVE;
        else if (stat_i.rel_last) state_d = S_ERASE;
        else state_d = S_RREL;
      end
      S_MOVE: begin
        cmd_o.op = pmfg_pkg::CMD_MOVE;
        state_d  = stat_i.rel_last ? S_ERASE : S_RREL;
      end
      S_ERASE: begin
        cmd_o.op = pmfg_pkg::CMD_ERASE;
        state_d  = S_HFWD;
      end
      S_HFWD: begin
        cmd_o.op = pmfg_pkg::CMD_RD_FWD;
        state_d  = S_HOLD;
      end
      S_HOLD: begin
        cmd_o.op = pmfg_pkg::CMD_RD_OLD;
        state_d  = S_HINV;
      end
      S_HINV: begin
        cmd_o.op = pmfg_pkg::CMD_INVAL;
        state_d  = stat_i.slot_ok ? S_HPROG : S_DONE;
      end
      S_HPROG: begin
        cmd_o.op = pmfg_pkg::CMD_HOST_PROG;
        state_d  = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.op    = pmfg_pkg::CMD_RESULT;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

  `PMFG_ASSERT_IMP(a_no_overwrite, cmd_o.op == pmfg_pkg::CMD_RESULT, !out_valid_q || out_ready_i, "pending result overwritten")

endmodule

FILE: src/page_mapped_ftl_greedy_gc.sv
// Top level of the page-mapped FTL with greedy garbage collection.
// Depends on pmfg_pkg, pmfg_ctrl and pmfg_dp.
//
//  Channel  Signals                                   Direction
//  in       in_valid_i/in_ready_o, logical_page_i     host -> block
//  out      out_valid_o/out_ready_i, result fields    block -> host
//  cfg      cfg_valid_i/cfg_ready_o, index, data      host -> block
//
// A clear pass after reset empties the maps and valid counts; no item is
// taken until it ends, configuration writes are always taken.
// An ordinary write steps through accept, range check, map read, old-copy
// read, invalidate, program and result load. Too few free blocks add a
// valid-count scan and a decision step, then a read and check of each victim
// page, a move of each live one and one erase. A pending result stalls only the result load.
`timescale 1ns / 1ps

module page_mapped_ftl_greedy_gc (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic [pmfg_pkg::LPN_W-1:0]       logical_page_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic [pmfg_pkg::PPN_W-1:0]       physical_page_o,
  output logic [pmfg_pkg::AP_W-1:0]        relocated_count_o,
  output logic                             gc_ran_o,
  output logic [pmfg_pkg::BLK_W-1:0]       victim_block_o,
  output logic [pmfg_pkg::ST_W-1:0]        status_o,
  output logic [pmfg_pkg::CNT_W-1:0]       total_host_writes_o,
  output logic [pmfg_pkg::CNT_W-1:0]       total_flash_writes_o,
  output logic [pmfg_pkg::CNT_W-1:0]       total_erases_o,
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [pmfg_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [pmfg_pkg::CFG_DATA_W-1:0]  cfg_data_i
);

  pmfg_pkg::cmd_t  cmd;
  pmfg_pkg::stat_t stat;

  // Registers are plain flops: take every write at once.
  assign cfg_ready_o = 1'b1;

  // Sequence the steps of each item.
  pmfg_ctrl u_ctrl (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_ready_o,
    .out_valid_o,
    .out_ready_i,
    .stat_i (stat),
    .cmd_o  (cmd)
  );

  // Hold maps, counts, append point and the result register.
  pmfg_dp u_dp (
    .clk_i,
    .rst_ni,
    .cmd_i  (cmd),
    .stat_o (stat),
    .cfg_valid_i (cfg_valid_i && cfg_ready_o),
    .cfg_index_i,
    .cfg_data_i,
    .logical_page_i,
    .physical_page_o,
    .relocated_count_o,
    .gc_ran_o,
    .victim_block_o,
    .status_o,
    .total_host_writes_o,
    .total_flash_writes_o,
    .total_erases_o
  );

endmodule

FILE: tb/pmfg_write_checker.sv
// Watches the write, result and register channels of the FTL block, keeps its own
// copy of the maps and counters, and compares every result item in order.
// Depends on pmfg_pkg.
`timescale 1ns / 1ps

module pmfg_write_checker (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  input  logic                            in_ready_i,
  input  logic [pmfg_pkg::LPN_W-1:0]      logical_page_i,
  input  logic                            out_valid_i,
  input  logic                            out_ready_i,
  input  logic [pmfg_pkg::PPN_W-1:0]      physical_page_i,
  input  logic [pmfg_pkg::AP_W-1:0]       relocated_count_i,
  input  logic                            gc_ran_i,
  input  logic [pmfg_pkg::BLK_W-1:0]      victim_block_i,
  input  logic [pmfg_pkg::ST_W-1:0]       status_i,
  input  logic [pmfg_pkg::CNT_W-1:0]      total_host_writes_i,
  input  logic [pmfg_pkg::CNT_W-1:0]      total_flash_writes_i,
  input  logic [pmfg_pkg::CNT_W-1:0]      total_erases_i,
  input  logic                            cfg_valid_i,
  input  logic                            cfg_ready_i,
  input  logic [pmfg_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [pmfg_pkg::CFG_DATA_W-1:0] cfg_data_i,
  output int                              errors_o,
  output int                              pending_o
);
  import pmfg_pkg::*;

  typedef struct packed {
    logic [PPN_W-1:0] ppn;
    logic [AP_W-1:0]  moved;
    logic             ran;
    logic [BLK_W-1:0] victim;
    logic [ST_W-1:0]  status;
    logic [CNT_W-1:0] host_cnt;
    logic [CNT_W-1:0] flash_cnt;
    logic [CNT_W-1:0] erase_cnt;
  } write_result_t;

  logic             fwd_live [MAX_LP];
  logic [PPN_W-1:0] fwd_ppn  [MAX_LP];
  logic             rev_live [PHYS_PAGES];
  logic [LPN_W-1:0] rev_lpn  [PHYS_PAGES];
  int               blk_valid [NUM_BLOCKS];
  int               open_blk, open_pg;
  logic [CNT_W-1:0] host_cnt, flash_cnt, erase_cnt;
  logic [BIU_W-1:0] biu;
  logic [LPL_W-1:0] lpl;
  write_result_t    result_q[$];
  int               errors;

  assign errors_o  = errors;
  assign pending_o = result_q.size();

  function automatic int managed_blocks();
    return (biu > NUM_BLOCKS) ? NUM_BLOCKS : int'(biu);
  endfunction

  function automatic int lowest_free_block(input int skip);
    for (int b = 0; b < managed_blocks(); b++)
      if (b != open_blk && b != skip && blk_valid[b] == 0) return b;
    return NUM_BLOCKS;
  endfunction

  function automatic int free_block_count();
    int c;
    c = 0;
    for (int b = 0; b < managed_blocks(); b++)
      if (b != open_blk && blk_valid[b] == 0) c++;
    return c;
  endfunction

  // Program one page at the append point, opening a new block when full.
  function automatic bit place_page(input logic [LPN_W-1:0] lpn, input int skip,
                                    output logic [PPN_W-1:0] ppn);
    int nb, p;
    ppn = '0;
    if (open_pg >= PPB) begin
      nb = lowest_free_block(skip);
      if (nb >= NUM_BLOCKS) return 0;
      open_blk = nb;
      open_pg  = 0;
    end
    p = open_blk * PPB + open_pg;
    open_pg++;
    rev_live[p] = 1'b1;
    rev_lpn[p]  = lpn;
    blk_valid[open_blk]++;
    fwd_live[lpn] = 1'b1;
    fwd_ppn[lpn]  = PPN_W'(p);
    flash_cnt++;
    ppn = PPN_W'(p);
    return 1;
  endfunction

  function automatic write_result_t predict_write(input logic [LPN_W-1:0] lpn);
    write_result_t r;
    int limit, nfree, best, v, room, idx, op, ob;
    logic [PPN_W-1:0] np;
    logic [LPN_W-1:0] moving;
    bit old_live, slot;
    r = '0;
    limit = (lpl > MAX_LP) ? MAX_LP : int'(lpl);
    if (int'(lpn) >= limit) begin
      r.status = ST_RANGE;
    end else begin
      nfree = free_block_count();
      if (nfree < 2) begin
        // greedy pick: fewest live pages, lowest index on ties
        best = PPB + 1;
        v = NUM_BLOCKS;
        for (int b = 0; b < managed_blocks(); b++) begin
          if (b == open_blk || blk_valid[b] == 0) continue;
          if (blk_valid[b] < best) begin
            best = blk_valid[b];
            v = b;
          end
        end
        if (v < NUM_BLOCKS) begin
          room = nfree * PPB + ((open_pg < PPB) ? PPB - open_pg : 0);
          if (blk_valid[v] <= room) begin
            for (int j = 0; j < PPB; j++) begin
              idx = v * PPB + j;
              if (!rev_live[idx]) continue;
              moving = rev_lpn[idx];
              rev_live[idx] = 1'b0;
              if (blk_valid[v] > 0) blk_valid[v]--;
              if (place_page(moving, v, np)) r.moved++;
            end
            blk_valid[v] = 0;
            for (int j = 0; j < PPB; j++) rev_live[v * PPB + j] = 1'b0;
            erase_cnt++;
            r.ran = 1'b1;
            r.victim = BLK_W'(v);
          end
        end
      end
      op = int'(fwd_ppn[lpn]);
      old_live = fwd_live[lpn] && rev_live[op];
      ob = op / PPB;
      slot = (open_pg < PPB) || (lowest_free_block(NUM_BLOCKS) < NUM_BLOCKS) ||
             (old_live && ob < managed_blocks() && ob != open_blk && blk_valid[ob] == 1);
      if (!slot) begin
        r.status = ST_WEDGED;
      end else begin
        if (old_live) begin
          rev_live[op] = 1'b0;
          if (blk_valid[ob] > 0) blk_valid[ob]--;
        end
        fwd_live[lpn] = 1'b0;
        fwd_ppn[lpn]  = '0;
        host_cnt++;
        if (!place_page(lpn, NUM_BLOCKS, np)) begin
          np = '0;
          r.status = ST_WEDGED;
        end
        r.ppn = np;
      end
    end
    r.host_cnt  = host_cnt;
    r.flash_cnt = flash_cnt;
    r.erase_cnt = erase_cnt;
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    write_result_t got, want;
    if (!rst_ni) begin
      for (int i = 0; i < MAX_LP; i++) begin
        fwd_live[i] = 1'b0;
        fwd_ppn[i]  = '0;
      end
      for (int i = 0; i < PHYS_PAGES; i++) begin
        rev_live[i] = 1'b0;
        rev_lpn[i]  = '0;
      end
      for (int i = 0; i < NUM_BLOCKS; i++) blk_valid[i] = 0;
      open_blk = 0;
      open_pg = 0;
      host_cnt = '0;
      flash_cnt = '0;
      erase_cnt = '0;
      biu = BIU_RESET;
      lpl = LPL_RESET;
      result_q.delete();
      errors = 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          CFG_BLOCKS_IN_USE: biu = cfg_data_i[BIU_W-1:0];
          CFG_LOGICAL_PAGES: lpl = cfg_data_i[LPL_W-1:0];
          default: ;
        endcase
      end
      if (in_valid_i && in_ready_i) result_q.push_back(predict_write(logical_page_i));
      if (out_valid_i && out_ready_i) begin
        got = '{physical_page_i, relocated_count_i, gc_ran_i, victim_block_i, status_i,
                total_host_writes_i, total_flash_writes_i, total_erases_i};
        if (result_q.size() == 0) begin
          errors++;
          if (errors <= 10) $display("unexpected result item %p", got);
        end else begin
          want = result_q.pop_front();
          if (got !== want) begin
            errors++;
            if (errors <= 10) $display("result mismatch: expected %p, actual %p", want, got);
          end
        end
      end
    end
  end

endmodule

FILE: tb/tb_page_mapped_ftl_greedy_gc.sv
// Stimulus and verdict for the page-mapped FTL with greedy garbage collection.
// Depends on pmfg_pkg, page_mapped_ftl_greedy_gc and pmfg_write_checker.
`timescale 1ns / 1ps

module tb_page_mapped_ftl_greedy_gc;
  import pmfg_pkg::*;

  // An index the register file does not decode; writes to it must be ignored.
  localparam logic [CFG_IDX_W-1:0] CFG_UNMAPPED = CFG_IDX_W'(3);
  localparam int HOLD_CYCLES = 3000;
  localparam int CYCLE_LIMIT = 2_000_000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic [LPN_W-1:0] logical_page_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic [PPN_W-1:0] physical_page_o;
  logic [AP_W-1:0] relocated_count_o;
  logic gc_ran_o;
  logic [BLK_W-1:0] victim_block_o;
  logic [ST_W-1:0] status_o;
  logic [CNT_W-1:0] total_host_writes_o, total_flash_writes_o, total_erases_o;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;

  int errors, pending;
  int cycles = 0;
  bit idle_on = 1'b1;    // random gaps between items when set
  bit hold_req = 1'b0;   // ask the result side for one long stall

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  page_mapped_ftl_greedy_gc uut (.*);

  pmfg_write_checker u_checker (
    .clk_i, .rst_ni,
    .in_valid_i, .in_ready_i(in_ready_o), .logical_page_i,
    .out_valid_i(out_valid_o), .out_ready_i,
    .physical_page_i(physical_page_o), .relocated_count_i(relocated_count_o),
    .gc_ran_i(gc_ran_o), .victim_block_i(victim_block_o), .status_i(status_o),
    .total_host_writes_i(total_host_writes_o), .total_flash_writes_i(total_flash_writes_o),
    .total_erases_i(total_erases_o),
    .cfg_valid_i, .cfg_ready_i(cfg_ready_o), .cfg_index_i, .cfg_data_i,
    .errors_o(errors), .pending_o(pending)
  );

  // Abort a hung run; the limit covers the clear pass, collection-heavy
  // items and the long result stall with a wide margin.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("FAIL page_mapped_ftl_greedy_gc");
      $finish;
    end
  end

  // Result side: random stalls per item, plus one long hold on request so
  // the block backs up and stops taking writes.
  initial begin
    int gap;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        out_ready_i <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        hold_req = 1'b0;
      end
      gap = idle_on ? $urandom_range(0, 5) : 0;
      if (gap > 0) begin
        out_ready_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      while (!out_valid_o) @(posedge clk_i);
    end
  end

  // Offer one write; returns at the edge where it is taken, valid still high.
  task automatic write_page(input logic [LPN_W-1:0] lpn);
    int gap;
    gap = idle_on ? $urandom_range(0, 5) : 0;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    logical_page_i <= lpn;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
  endtask

  // Drop valid and wait until every predicted result has come back.
  task automatic drain();
    in_valid_i <= 1'b0;
    repeat (2) @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset settings: bounds of the logical range, overwrites, bit patterns.
    write_page(12'd0);
    write_page(12'd4095);
    write_page(12'd3583);
    write_page(12'd3584);
    write_page(12'd0);
    write_page(12'hAAA);
    write_page(12'h555);
    write_page(12'd0);
    drain();

    // Ignored index, then everything rejected, then a single legal page.
    write_reg(CFG_UNMAPPED, 13'h1FFF);
    write_reg(CFG_LOGICAL_PAGES, 13'd0);
    write_page(12'd0);
    write_page(12'd4095);
    drain();
    write_reg(CFG_LOGICAL_PAGES, 13'd1);
    write_page(12'd0);
    write_page(12'd1);
    write_page(12'd0);
    drain();

    // Three blocks: collection on nearly every block turn, and a growing
    // live set pushes the block into the wedged state.
    write_reg(CFG_BLOCKS_IN_USE, 13'd3);
    write_reg(CFG_LOGICAL_PAGES, 13'h1FFF);
    for (int i = 0; i < 250; i++) begin
      if (i == 60) idle_on = 1'b0;
      if (i == 100) idle_on = 1'b1;
      write_page(LPN_W'(i < 180 ? $urandom_range(0, 90) : $urandom_range(0, 260)));
    end
    drain();

    // Four blocks with a small range; long result stall in the middle.
    write_reg(CFG_BLOCKS_IN_USE, 13'd4);
    write_reg(CFG_LOGICAL_PAGES, 13'd200);
    for (int i = 0; i < 250; i++) begin
      if (i == 80) hold_req = 1'b1;
      write_page(LPN_W'($urandom_range(0, 9) == 0 ? $urandom_range(0, 4095)
                                                  : $urandom_range(0, 220)));
    end
    drain();

    // Oversized block count acts as all blocks; full logical range.
    write_reg(CFG_BLOCKS_IN_USE, 13'd127);
    write_reg(CFG_LOGICAL_PAGES, 13'd4096);
    for (int i = 0; i < 300; i++) write_page(LPN_W'($urandom_range(0, 4095)));
    drain();

    write_reg(CFG_BLOCKS_IN_USE, 13'd64);
    write_reg(CFG_LOGICAL_PAGES, 13'd3584);
    write_page(12'd4095);
    write_page(12'd17);
    drain();
    repeat (20) @(posedge clk_i);

    if (errors == 0) begin
      $display("PASS page_mapped_ftl_greedy_gc");
    end else begin
      $display("FAIL page_mapped_ftl_greedy_gc");
    end
    $finish;
  end

endmodule
